// ===== src/svg_pkg.sv =====
// svg_pkg: shared types and constants for the sparse vector gather block.
// Operation codes, sequencer states, memory port structs and beat layouts.
// No dependencies.
`timescale 1ns / 1ps

package svg_pkg;

    localparam int OFFSET_W    = 31;
    localparam int VALUE_W     = 64;
    localparam int COUNT31_W   = 31;
    localparam int RANK_W      = 10;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 136;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_MID,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                en;
        logic [OFFSET_W-1:0] offset;
        logic [VALUE_W-1:0]  value;
    } mem_wr_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [VALUE_W-1:0]  value;
    } mem_rd_t;

    typedef struct packed {
        op_t                 op;
        logic [OFFSET_W-1:0] entry_offset;
        logic [VALUE_W-1:0]  entry_value;
        logic [OFFSET_W-1:0] query_offset;
    } in_beat_t;

    // Packed so that out_position lands in the lowest bits of tdata.
    typedef struct packed {
        logic [VALUE_W-1:0]   out_value;
        logic [RANK_W-1:0]    source_rank;
        logic [COUNT31_W-1:0] out_rank;
        logic [COUNT31_W-1:0] out_position;
    } out_beat_t;

endpackage

// ===== src/svg_store.sv =====
// svg_store: offset and value memories of the sparse vector.
// One write port and one registered read port.
// Depends on svg_pkg.
`timescale 1ns / 1ps

module svg_store #(
    parameter int AW = 10
) (
    input  logic             clk,
    input  svg_pkg::mem_wr_t wr,
    input  logic [AW-1:0]    wr_addr,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output svg_pkg::mem_rd_t rd
);

    localparam int DEPTH = 1 << AW;

    logic [svg_pkg::OFFSET_W-1:0] offset_mem [DEPTH];
    logic [svg_pkg::VALUE_W-1:0]  value_mem  [DEPTH];
    svg_pkg::mem_rd_t             rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            offset_mem[wr_addr] <= wr.offset;
            value_mem[wr_addr]  <= wr.value;
        end
    end

    // Read data holds while no read is issued; the emit step relies on it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg.offset <= offset_mem[rd_addr];
            rd_data_reg.value  <= value_mem[rd_addr];
        end
    end

    assign rd = rd_data_reg;

endmodule

// ===== src/svg_search.sv =====
// svg_search: item sequencer, counters, binary search and result register.
// Drives the store's ports; one item is handled at a time.
// Depends on svg_pkg.
`timescale 1ns / 1ps

module svg_search #(
    parameter int MAX_NONZERO = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  svg_pkg::in_beat_t              in_beat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output svg_pkg::out_beat_t             out_beat,
    output svg_pkg::mem_wr_t               wr,
    output logic [$clog2(MAX_NONZERO)-1:0] wr_addr,
    output logic                           rd_en,
    output logic [$clog2(MAX_NONZERO)-1:0] rd_addr,
    input  svg_pkg::mem_rd_t               rd
);

    localparam int AW = $clog2(MAX_NONZERO);
    localparam int CW = $clog2(MAX_NONZERO + 1);
    localparam int PW = svg_pkg::COUNT31_W;

    svg_pkg::state_t               state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [PW-1:0]                 qpos_reg, qpos_next;
    logic [PW-1:0]                 hits_reg, hits_next;
    logic [svg_pkg::OFFSET_W-1:0]  key_reg, key_next;
    logic [PW-1:0]                 pos_reg, pos_next;
    logic [AW-1:0]                 lo_reg, lo_next;
    logic [AW-1:0]                 hi_reg, hi_next;
    logic [AW-1:0]                 probe_reg, probe_next;
    logic                          out_valid_reg, out_valid_next;
    svg_pkg::out_beat_t            out_reg, out_next;
    logic [AW-1:0]                 mid;

    function automatic logic [AW-1:0] mid_of(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[AW:1];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svg_pkg::ST_IDLE;
            count_reg     <= '0;
            qpos_reg      <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            qpos_reg      <= qpos_next;
            hits_reg      <= hits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        pos_reg   <= pos_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        probe_reg <= probe_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        qpos_next      = qpos_reg;
        hits_next      = hits_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        probe_next     = probe_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mid            = mid_of(lo_reg, hi_reg);

        wr.en     = 1'b0;
        wr.offset = in_beat.entry_offset;
        wr.value  = in_beat.entry_value;
        wr_addr   = count_reg[AW-1:0];
        rd_en     = 1'b0;
        rd_addr   = probe_reg;
        in_ready  = (state_reg == svg_pkg::ST_IDLE);

        unique case (state_reg)
            svg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_beat.op)
                        svg_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        svg_pkg::OP_LOAD:
                        begin
                            if (count_reg < CW'(MAX_NONZERO))
                            begin
                                wr.en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        svg_pkg::OP_START:
                        begin
                            qpos_next = '0;
                            hits_next = '0;
                        end
                        svg_pkg::OP_QUERY:
                        begin
                            key_next  = in_beat.query_offset;
                            pos_next  = qpos_reg;
                            qpos_next = qpos_reg + 1'b1;
                            // empty store: miss, no probe
                            if (count_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                probe_next = '0;
                                state_next = svg_pkg::ST_FIRST;
                            end
                        end
                    endcase
                end
            end
            svg_pkg::ST_FIRST:
            begin
                priority if (key_reg < rd.offset)
                begin
                    state_next = svg_pkg::ST_IDLE;
                end
                else if (key_reg == rd.offset)
                begin
                    state_next = svg_pkg::ST_EMIT;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = AW'(count_reg - 1'b1);
                    rd_en      = 1'b1;
                    rd_addr    = hi_next;
                    probe_next = hi_next;
                    state_next = svg_pkg::ST_LAST;
                end
            end
            svg_pkg::ST_LAST:
            begin
                priority if (key_reg > rd.offset)
                begin
                    state_next = svg_pkg::ST_IDLE;
                end
                else if (key_reg == rd.offset)
                begin
                    state_next = svg_pkg::ST_EMIT;
                end
                else if (mid == lo_reg)
                begin
                    state_next = svg_pkg::ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid;
                    probe_next = mid;
                    state_next = svg_pkg::ST_MID;
                end
            end
            svg_pkg::ST_MID:
            begin
                if (key_reg == rd.offset)
                begin
                    state_next = svg_pkg::ST_EMIT;
                end
                else
                begin
                    // narrow the range, then issue the next probe in the same cycle
                    if (key_reg > rd.offset)
                    begin
                        lo_next = probe_reg;
                    end
                    else
                    begin
                        hi_next = probe_reg;
                    end
                    mid = mid_of(lo_next, hi_next);
                    if (mid == lo_next)
                    begin
                        state_next = svg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = mid;
                        probe_next = mid;
                    end
                end
            end
            svg_pkg::ST_EMIT:
            begin
                // read data still holds the matched entry
                if (!out_valid_reg || out_ready)
                begin
                    out_next.out_position = pos_reg;
                    out_next.out_rank     = hits_reg;
                    out_next.source_rank  = svg_pkg::RANK_W'(probe_reg);
                    out_next.out_value    = rd.value;
                    out_valid_next        = 1'b1;
                    hits_next             = hits_reg + 1'b1;
                    state_next            = svg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = svg_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

endmodule

// ===== src/sparse_vector_gather_top.sv =====
// Channel  Dir  Signals                               Beat
// s        in   s_tvalid s_tready s_tdata s_tuser     one operation item
// m        out  m_tvalid m_tready m_tdata             one hit result
//
// Clear, load and start-pass are each taken in the idle state. A query on an
// empty store misses with no probe; otherwise the search makes one probe per cycle
// through the single read port of the store memories, plus the emit step on a hit.
// Reset is asynchronous and active low; it empties the store and zeroes counters.
// A finished result waits in the output register while the next item is taken;
// a hit that finds the register still full holds the block until m_tready.
// Depends on svg_pkg, svg_store, svg_search.
`timescale 1ns / 1ps

module sparse_vector_gather_top #(
    parameter int MAX_NONZERO = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [30:0] entry_offset, [94:31] entry_value, [125:95] query_offset, [127:126] zero
    input  logic [svg_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [1:0] operation
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [30:0] out_position, [61:31] out_rank, [71:62] source_rank, [135:72] out_value
    output logic [svg_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int AW = $clog2(MAX_NONZERO);

    svg_pkg::in_beat_t  in_beat;
    svg_pkg::out_beat_t out_beat;
    svg_pkg::mem_wr_t   wr;
    svg_pkg::mem_rd_t   rd;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;

    always_comb
    begin
        in_beat.op           = svg_pkg::op_t'(s_tuser);
        in_beat.entry_offset = s_tdata[30:0];
        in_beat.entry_value  = s_tdata[94:31];
        in_beat.query_offset = s_tdata[125:95];
    end

    svg_search #(
        .MAX_NONZERO (MAX_NONZERO)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_beat   (in_beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat),
        .wr        (wr),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd        (rd)
    );

    svg_store #(
        .AW (AW)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd      (rd)
    );

    assign m_tdata = out_beat;

endmodule

// ===== src/svg_checker.sv =====
// svg_checker: port-level assertions for sparse_vector_gather_top.
// Bound to the top level at the end of this file. Depends on svg_pkg.
`timescale 1ns / 1ps

module svg_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [1:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [svg_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic s_beat;
    logic query_beat;

    assign s_beat     = s_tvalid && s_tready;
    assign query_beat = s_beat && (s_tuser == svg_pkg::OP_QUERY);

    // a stalled result holds
    a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // only a query can produce a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat && !query_beat && !m_tvalid |=> !m_tvalid)
        else $error("result appeared after a non-query beat");

    // the search needs at least one probe before a result
    a_probe_latency: assert property (@(posedge clk) disable iff (!rst_n)
        query_beat |=> !$rose(m_tvalid))
        else $error("result appeared the cycle after a query beat");

endmodule

bind sparse_vector_gather_top svg_checker u_svg_checker (.*);

// ===== bench/svg_gather_checker.sv =====
// svg_gather_checker: watches both stream channels of the sparse vector gather block,
// predicts each hit beat from accepted operation beats and compares field by field.
// Depends on svg_pkg.
`timescale 1ns / 1ps

module svg_gather_checker #(
    parameter int DEPTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [svg_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [svg_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                              mismatches,
    output int                              hits_pending
);

    localparam int NO_HIT = -1;

    typedef struct packed {
        logic [30:0] position;
        logic [30:0] rank;
        logic [9:0]  src_rank;
        logic [63:0] value;
    } gather_hit_t;

    // shadow copy of the block's store and pass counters
    logic [30:0] offs [DEPTH];
    logic [63:0] vals [DEPTH];
    int          fill;
    logic [30:0] pass_pos;
    logic [30:0] pass_hits;
    gather_hit_t hits_due [$];
    int          err_n = 0;

    // first/last compare, then bisection over the stored order (ascending or not)
    function automatic int locate_offset(input logic [30:0] key);
        int lo;
        int hi;
        int mid;
        if (fill == 0)
            return NO_HIT;
        lo = 0;
        if (key < offs[0])
            return NO_HIT;
        if (key == offs[0])
            return 0;
        hi = fill - 1;
        if (key > offs[hi])
            return NO_HIT;
        if (key == offs[hi])
            return hi;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (key == offs[mid])
                return mid;
            if (key > offs[mid])
                lo = mid;
            else
                hi = mid;
        end
        return NO_HIT;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        gather_hit_t got;
        gather_hit_t want;
        int          k;
        logic [30:0] q_key;
        if (!rst_n)
        begin
            fill      = 0;
            pass_pos  = '0;
            pass_hits = '0;
            hits_due.delete();
        end
        else
        begin
            // result beat: a hit can never come from a beat accepted on this same edge
            if (m_tvalid && m_tready)
            begin
                got.position = m_tdata[30:0];
                got.rank     = m_tdata[61:31];
                got.src_rank = m_tdata[71:62];
                got.value    = m_tdata[135:72];
                if (hits_due.size() == 0)
                begin
                    $error("unexpected result beat: out_position %0d out_rank %0d",
                           got.position, got.rank);
                    err_n++;
                end
                else
                begin
                    want = hits_due.pop_front();
                    if (got.position !== want.position)
                    begin
                        $error("out_position: expected %0d, got %0d",
                               want.position, got.position);
                        err_n++;
                    end
                    if (got.rank !== want.rank)
                    begin
                        $error("out_rank: expected %0d, got %0d", want.rank, got.rank);
                        err_n++;
                    end
                    if (got.src_rank !== want.src_rank)
                    begin
                        $error("source_rank: expected %0d, got %0d",
                               want.src_rank, got.src_rank);
                        err_n++;
                    end
                    if (got.value !== want.value)
                    begin
                        $error("out_value: expected %h, got %h", want.value, got.value);
                        err_n++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                case (svg_pkg::op_t'(s_tuser))
                    svg_pkg::OP_CLEAR:
                        fill = 0;
                    svg_pkg::OP_LOAD:
                        if (fill < DEPTH)
                        begin
                            offs[fill] = s_tdata[30:0];
                            vals[fill] = s_tdata[94:31];
                            fill++;
                        end
                    svg_pkg::OP_START:
                    begin
                        pass_pos  = '0;
                        pass_hits = '0;
                    end
                    svg_pkg::OP_QUERY:
                    begin
                        q_key = s_tdata[125:95];
                        k     = locate_offset(q_key);
                        if (k != NO_HIT)
                        begin
                            want.position = pass_pos;
                            want.rank     = pass_hits;
                            want.src_rank = k[9:0];
                            want.value    = vals[k];
                            hits_due.push_back(want);
                            pass_hits = pass_hits + 31'd1;
                        end
                        // misses advance the position too; 31-bit wrap is natural
                        pass_pos = pass_pos + 31'd1;
                    end
                    default: ;
                endcase
            end
        end
        mismatches   <= err_n;
        hits_pending <= hits_due.size();
    end

endmodule

// ===== bench/tb_sparse_vector_gather_top.sv =====
// tb_sparse_vector_gather_top: stimulus and verdict for sparse_vector_gather_top.
// Drives directed and random operation beats with random gaps and output stalls;
// checking is done by svg_gather_checker. Depends on svg_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_sparse_vector_gather_top;

    localparam int          DEPTH        = 1024;
    localparam int          ITEMS        = 1650;
    localparam int          DRAIN_CYCLES = 24;
    localparam longint      LIMIT31      = 64'h7fff_ffff;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [svg_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]                      s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [svg_pkg::OUT_TDATA_W-1:0] m_tdata;

    logic                   no_idle   = 1'b0;
    int                     stall_left = 0;
    int                     items_sent = 0;
    int                     mismatches;
    int                     hits_pending;
    logic [30:0]            known [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sparse_vector_gather_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    svg_gather_checker #(.DEPTH(DEPTH)) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .hits_pending (hits_pending)
    );

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [30:0] rand31();
        return 31'($urandom);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    // one operation beat; returns once accepted
    task automatic send_item(input svg_pkg::op_t op, input logic [30:0] eoff,
                             input logic [63:0] eval, input logic [30:0] qoff);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, qoff, eval, eoff};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (op == svg_pkg::OP_CLEAR)
            known.delete();
        else if (op == svg_pkg::OP_LOAD && known.size() < DEPTH)
            known.push_back(eoff);
    endtask

    task automatic load(input logic [30:0] eoff, input logic [63:0] eval);
        send_item(svg_pkg::OP_LOAD, eoff, eval, rand31());
    endtask

    task automatic query(input logic [30:0] key);
        send_item(svg_pkg::OP_QUERY, rand31(), rand64(), key);
    endtask

    task automatic plain(input svg_pkg::op_t op);
        send_item(op, rand31(), rand64(), rand31());
    endtask

    function automatic logic [30:0] pick_key();
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if (known.size() == 0 || r >= 90)
        begin
            case ($urandom_range(0, 5))
                0:       return '0;
                1:       return '1;
                default: return rand31();
            endcase
        end
        idx = $urandom_range(0, known.size() - 1);
        if (r < 65)
            return known[idx];
        if (r < 78)
            return $urandom_range(0, 1) ? known[idx] + 31'd1 : known[idx] - 31'd1;
        if ($urandom_range(0, 1))
            return known[0] - 31'd1;
        return known[known.size() - 1] + 31'd1;
    endfunction

    // clear (usually), load a mostly ascending run, open a pass (usually), then query it
    task automatic run_episode(input bit fill_up);
        int              n;
        int              nq;
        int              r;
        bit              dense;
        longint unsigned step_max;
        longint unsigned room;
        longint unsigned off;
        logic [30:0]     eoff;
        no_idle <= ($urandom_range(0, 3) == 0);
        if (fill_up || $urandom_range(0, 7) != 0)
            plain(svg_pkg::OP_CLEAR);
        if (fill_up)
            n = DEPTH + 3;
        else
        begin
            r = $urandom_range(0, 9);
            n = (r == 0) ? 0 : (r < 7) ? $urandom_range(1, 12) : $urandom_range(13, 64);
        end
        dense    = ($urandom_range(0, 2) == 0);
        step_max = dense ? 3 : $urandom_range(4, LIMIT31 / (n + 1));
        room     = step_max * n;
        case ($urandom_range(0, 2))
            0:       off = $urandom_range(0, 7);
            1:       off = LIMIT31 - room;
            default: off = $urandom_range(0, LIMIT31 - room);
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                off += $urandom_range(1, step_max);
            // occasional out-of-order offset
            eoff = (!fill_up && $urandom_range(0, 19) == 0) ? rand31() : off[30:0];
            load(eoff, rand64());
        end
        if ($urandom_range(0, 9) != 0)
            plain(svg_pkg::OP_START);
        nq = fill_up ? 80 : $urandom_range(4, 40);
        for (int q = 0; q < nq; q++)
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                case ($urandom_range(0, 2))
                    0:       plain(svg_pkg::OP_CLEAR);
                    1:       plain(svg_pkg::OP_START);
                    default: load(rand31(), rand64());
                endcase
            end
            else
                query(pick_key());
        end
    endtask

    initial
    begin : stimulus
        int episode;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty store, extremes of offsets and values
        query(rand31());
        load('0, 64'h0);
        load(31'd5, '1);
        load(31'd1000, 64'h8000_0000_0000_0001);
        load(31'h7fff_fffe, rand64());
        load('1, 64'h5555_5555_aaaa_aaaa);
        plain(svg_pkg::OP_START);
        query('0);
        query('1);
        query(31'd1000);
        query(31'd3);
        query(31'd5);
        query(31'h7fff_fffe);
        // clear keeps position and rank counting
        plain(svg_pkg::OP_CLEAR);
        query('0);
        // offsets out of order
        load(31'd100, rand64());
        load(31'd50, rand64());
        load(31'd200, rand64());
        load(31'd10, rand64());
        query(31'd50);
        query(31'd10);
        query(31'd100);
        query(31'd200);
        query(31'd7);
        query('1);
        plain(svg_pkg::OP_START);

        episode = 0;
        while (items_sent < ITEMS)
        begin
            run_episode(episode == 2);
            episode++;
        end
        s_tvalid <= 1'b0;
        no_idle  <= 1'b0;

        @(posedge clk);
        while (hits_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** sparse_vector_gather_top: PASSED **");
        else
            $display("** sparse_vector_gather_top: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #(64'd20_000_000);
        $display("** sparse_vector_gather_top: FAILED **");
        $finish;
    end

endmodule
